FILE: rtl/integer_string_parser_unit_assert.svh
// Assertion macros for the integer string parser unit.
// Included by the top level; expects clk and rst in scope.
`ifndef INTEGER_STRING_PARSER_UNIT_ASSERT_SVH
`define INTEGER_STRING_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ISP_ASSERT_IMPLY(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("isp assertion failed");

// Next-cycle implication.
`define ISP_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("isp assertion failed");

`endif

FILE: rtl/isp_pkg.sv
// Package for the integer string parser unit: widths, codes, word and state types.
// No dependencies.
package isp_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAG_W      = VALUE_BITS + 1;
  localparam int BASE_W     = 6;
  localparam int CHAR_W     = 8;

  localparam logic [0:0] REG_RADIX  = 1'b0;
  localparam logic [0:0] REG_PREFIX = 1'b1;

  localparam logic [BASE_W-1:0] RADIX_RESET = BASE_W'(10);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_BADDIGIT  = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SIGN   = 3'd1,
    PH_ZERO   = 3'd2,
    PH_PREFIX = 3'd3,
    PH_DIGITS = 3'd4
  } phase_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              has_character;
    logic              last;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] number;
    status_t                      status;
  } out_word_t;

  typedef struct packed {
    logic [BASE_W-1:0] radix;
    logic              prefix_decode;
  } cfg_t;

  typedef struct packed {
    logic [MAG_W-1:0]  magnitude;
    logic              is_negative;
    phase_t            phase;
    logic [BASE_W-1:0] active_base;
    status_t           error_code;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    magnitude:   '0,
    is_negative: 1'b0,
    phase:       PH_START,
    active_base: BASE_W'(10),
    error_code:  ST_OK
  };

endpackage

FILE: rtl/isp_step.sv
// One parse step: next parse state and end-of-string result from the current
// state, one input word and the configuration. Depends on isp_pkg.
module isp_step
  import isp_pkg::*;
(
  input  parse_state_t state,
  input  in_word_t     word,
  input  cfg_t         cfg,
  output parse_state_t state_next,
  output out_word_t    result
);

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam int PROD_W = MAG_W + BASE_W;
  localparam logic [MAG_W-1:0]  LIMIT   = MAG_W'(1) << (VALUE_BITS - 1);
  localparam logic [PROD_W-1:0] LIMIT_P = PROD_W'(LIMIT);

  function automatic logic [CHAR_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] v;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h7A) v = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h5A) v = c - 8'h37;
    else v = 8'hFF;
    return v;
  endfunction

  parse_state_t      s;
  status_t           err_pre;
  logic              do_digit;
  logic              do_decode;
  logic [BASE_W-1:0] dbase;
  logic [CHAR_W-1:0] dv;
  logic [PROD_W-1:0] prod;
  logic [MAG_W-1:0]  neg_mag;
  status_t           st;
  logic [VALUE_BITS-1:0] num;

  assign dv = digit_value(word.character);

  always_comb begin
    err_pre = state.error_code;
    if (state.phase == PH_START && state.error_code == ST_OK && !cfg.prefix_decode &&
        (cfg.radix < BASE_W'(2) || cfg.radix > BASE_W'(36))) begin
      err_pre = ST_MALFORMED;
    end

    s            = state;
    s.error_code = err_pre;
    do_digit     = 1'b0;
    do_decode    = 1'b0;
    dbase        = state.active_base;
    prod         = '0;

    if (word.has_character && err_pre == ST_OK) begin
      case (state.phase)
        PH_START: begin
          s.active_base = cfg.prefix_decode ? BASE_W'(10) : cfg.radix;
          if (word.character == CH_MINUS) begin
            s.is_negative = 1'b1;
            s.phase       = PH_SIGN;
          end else if (cfg.prefix_decode) begin
            do_decode = 1'b1;
          end else begin
            do_digit = 1'b1;
            dbase    = cfg.radix;
          end
        end
        PH_SIGN: begin
          if (cfg.prefix_decode) do_decode = 1'b1;
          else do_digit = 1'b1;
        end
        PH_ZERO: begin
          if (word.character == CH_LX || word.character == CH_UX) begin
            s.active_base = BASE_W'(16);
            s.phase       = PH_PREFIX;
          end else begin
            s.active_base = BASE_W'(8);
            do_digit      = 1'b1;
            dbase         = BASE_W'(8);
          end
        end
        default: do_digit = 1'b1;
      endcase

      if (do_decode) begin
        if (word.character == CH_ZERO) begin
          s.phase = PH_ZERO;
        end else if (word.character == CH_HASH) begin
          s.active_base = BASE_W'(16);
          s.phase       = PH_PREFIX;
        end else begin
          s.active_base = BASE_W'(10);
          do_digit      = 1'b1;
          dbase         = BASE_W'(10);
        end
      end

      prod = PROD_W'(state.magnitude) * PROD_W'(dbase) + PROD_W'(dv);

      if (do_digit) begin
        if (dv >= CHAR_W'(dbase)) begin
          s.error_code = ST_BADDIGIT;
        end else if (prod > LIMIT_P) begin
          s.error_code = ST_RANGE;
        end else begin
          s.magnitude = prod[MAG_W-1:0];
          s.phase     = PH_DIGITS;
        end
      end
    end

    neg_mag = MAG_W'(0) - s.magnitude;
    st      = s.error_code;
    num     = '0;
    if (st == ST_OK) begin
      if (s.phase == PH_START || s.phase == PH_SIGN || s.phase == PH_PREFIX) begin
        st = ST_MALFORMED;
      end else if (!s.is_negative && s.magnitude > LIMIT - MAG_W'(1)) begin
        st = ST_RANGE;
      end else begin
        num = s.is_negative ? neg_mag[VALUE_BITS-1:0] : s.magnitude[VALUE_BITS-1:0];
      end
    end
    result.status = st;
    result.number = (st == ST_OK) ? num : '0;

    if (!word.has_character && !word.last) state_next = state;
    else if (word.last) state_next = STATE_RESET;
    else state_next = s;
  end

endmodule

FILE: rtl/integer_string_parser_unit.sv
// Top level of the integer string parser unit: config registers, input stage,
// parse state and result register. Depends on isp_pkg, isp_step and the assert header.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------
//   in       | in_valid / in_ready    | in_word  (character, has_character, last)
//   out      | out_valid / out_ready  | out_word (number, status)
//   cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data (always ready)
//
// One word per cycle unless a last word waits on a stalled result; the last word goes
// from the input register through the combinational parse step into the result register.
// rst is synchronous: config back to radix 10, plain mode, parse state cleared.
// A stalled result holds only words that end a string; other words keep flowing.
`include "integer_string_parser_unit_assert.svh"

module integer_string_parser_unit
  import isp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_word,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [BASE_W-1:0] cfg_data
);

  cfg_t         cfg;
  logic         s1_valid;
  in_word_t     s1_word;
  logic         s1_fire;
  parse_state_t state;
  parse_state_t state_next;
  out_word_t    result;

  assign cfg_ready = 1'b1;
  assign s1_fire   = s1_valid && (!s1_word.last || !out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radix         <= RADIX_RESET;
      cfg.prefix_decode <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RADIX:  cfg.radix         <= cfg_data;
        REG_PREFIX: cfg.prefix_decode <= cfg_data[0];
      endcase
    end
  end

  isp_step u_step (
    .state      (state),
    .word       (s1_word),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (s1_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_word.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_word.last) begin
      out_word <= result;
    end
  end

  `ISP_ASSERT_NEXT(a_last_gives_result, s1_fire && s1_word.last, out_valid)
  `ISP_ASSERT_NEXT(a_last_clears_state, s1_fire && s1_word.last, state == STATE_RESET)
  `ISP_ASSERT_NEXT(a_state_holds_idle, !s1_fire, $stable(state))
  `ISP_ASSERT_IMPLY(a_error_zero_number, out_valid && out_word.status != ST_OK,
                    out_word.number == '0)

endmodule
